// ===== sv/ftss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftss_pkg
// Shared types, constants and helpers of the film tile sample splat unit.
// ----------------------------------------------------------------------------
package ftss_pkg;

   localparam int FILTER_TABLE_WIDTH = 16;
   localparam int TILE_DIM           = 32;

   localparam int TBL_N    = FILTER_TABLE_WIDTH * FILTER_TABLE_WIDTH;
   localparam int PIX_N    = TILE_DIM * TILE_DIM;
   localparam int TAW      = $clog2(TBL_N);
   localparam int PAW      = $clog2(PIX_N);
   localparam int IDXW     = $clog2(FILTER_TABLE_WIDTH);
   localparam int TWB      = $clog2(FILTER_TABLE_WIDTH + 1);
   localparam int CW       = 16;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_READ  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   localparam logic [2:0] CSR_TILE_X_MIN   = 3'd0;
   localparam logic [2:0] CSR_TILE_Y_MIN   = 3'd1;
   localparam logic [2:0] CSR_TILE_X_MAX   = 3'd2;
   localparam logic [2:0] CSR_TILE_Y_MAX   = 3'd3;
   localparam logic [2:0] CSR_RADIUS_X     = 3'd4;
   localparam logic [2:0] CSR_RADIUS_Y     = 3'd5;
   localparam logic [2:0] CSR_INV_RADIUS_X = 3'd6;
   localparam logic [2:0] CSR_INV_RADIUS_Y = 3'd7;

   typedef struct packed {
      action_type         action;
      logic [19:0]        pos_x;
      logic [19:0]        pos_y;
      logic [15:0]        red;
      logic [15:0]        green;
      logic [15:0]        blue;
      logic [15:0]        sample_weight;
      logic [7:0]         table_index;
      logic signed [15:0] table_weight;
      logic [11:0]        pixel_x;
      logic [11:0]        pixel_y;
   } req_type;

   typedef struct packed {
      logic signed [39:0] red_sum;
      logic signed [39:0] green_sum;
      logic signed [39:0] blue_sum;
      logic signed [31:0] weight_sum;
      logic               in_tile;
   } rsp_type;

   typedef struct packed {
      logic signed [39:0] red;
      logic signed [39:0] green;
      logic signed [39:0] blue;
      logic signed [31:0] weight;
   } acc_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SETUP,
      S_CHECK,
      S_IDX1,
      S_IDX2,
      S_MEMRD,
      S_MUL1,
      S_MUL2,
      S_WB,
      S_PIXRD,
      S_PIXOUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic tbl_we;
      logic clr_we;
      logic setup;
      logic idx1;
      logic idx2;
      logic mem_rd;
      logic mul1;
      logic mul2;
      logic acc_we;
      logic pix_rd;
      logic rsp_valid;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic last_pix;
      logic clr_last;
   } status_type;

   // Table index from |offset| * inv_radius (14 + 8 fraction bits), capped.
   function automatic logic [IDXW-1:0] tbl_idx(input logic [39:0] prod);
      logic [22+TWB-1:0] scaled;
      scaled = {{TWB{1'b0}}, prod[21:0]} * (22+TWB)'(FILTER_TABLE_WIDTH);
      if (|prod[39:22]) begin
         tbl_idx = IDXW'(FILTER_TABLE_WIDTH - 1);
      end else begin
         tbl_idx = IDXW'(scaled[22+TWB-1:22]);
      end
   endfunction

endpackage

// ===== sv/ftss_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ftss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/ftss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftss_ctrl
// Sequencer for request actions, per-pixel splat steps and tile clearing.
// ----------------------------------------------------------------------------
module ftss_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  ftss_pkg::action_type  action,
   input  ftss_pkg::status_type  status,
   output ftss_pkg::cmd_type     cmd,
   output logic                  busy
);
   import ftss_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_we = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (action)
                  ACT_LOAD:  cmd.tbl_we = 1'b1;
                  ACT_ADD:   state_in = S_SETUP;
                  ACT_READ:  state_in = S_PIXRD;
                  ACT_CLEAR: state_in = S_CLEAR;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            state_in = status.empty ? S_IDLE : S_IDX1;
         end
         S_IDX1: begin
            cmd.idx1 = 1'b1;
            state_in = S_IDX2;
         end
         S_IDX2: begin
            cmd.idx2 = 1'b1;
            state_in = S_MEMRD;
         end
         S_MEMRD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_WB;
         end
         S_WB: begin
            cmd.acc_we = 1'b1;
            state_in   = status.last_pix ? S_IDLE : S_IDX1;
         end
         S_PIXRD: begin
            cmd.pix_rd = 1'b1;
            state_in   = S_PIXOUT;
         end
         S_PIXOUT: begin
            cmd.rsp_valid = 1'b1;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== sv/ftss_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftss_dp
// Datapath: configuration, footprint, table indices, weighting, accumulators.
// ----------------------------------------------------------------------------
module ftss_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  ftss_pkg::cmd_type     cmd,
   output ftss_pkg::status_type  status,
   input  ftss_pkg::req_type     req_item,
   output ftss_pkg::rsp_type     rsp_item,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_wdata
);
   import ftss_pkg::*;

   logic [12:0] xmin_ff, ymin_ff, xmax_ff, ymax_ff;
   logic [10:0] rx_ff, ry_ff;
   logic [15:0] invx_ff, invy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         xmin_ff <= 13'd0;
         ymin_ff <= 13'd0;
         xmax_ff <= 13'd32;
         ymax_ff <= 13'd32;
         rx_ff   <= 11'd512;
         ry_ff   <= 11'd512;
         invx_ff <= 16'd8192;
         invy_ff <= 16'd8192;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TILE_X_MIN:   xmin_ff <= csr_wdata[12:0];
            CSR_TILE_Y_MIN:   ymin_ff <= csr_wdata[12:0];
            CSR_TILE_X_MAX:   xmax_ff <= csr_wdata[12:0];
            CSR_TILE_Y_MAX:   ymax_ff <= csr_wdata[12:0];
            CSR_RADIUS_X:     rx_ff   <= csr_wdata[10:0];
            CSR_RADIUS_Y:     ry_ff   <= csr_wdata[10:0];
            CSR_INV_RADIUS_X: invx_ff <= csr_wdata;
            CSR_INV_RADIUS_Y: invy_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective tile bounds: never more than TILE_DIM past the minimum.
   logic [13:0] cap_x, cap_y, emx, emy;
   assign cap_x = {1'b0, xmin_ff} + 14'(TILE_DIM);
   assign cap_y = {1'b0, ymin_ff} + 14'(TILE_DIM);
   assign emx   = ({1'b0, xmax_ff} < cap_x) ? {1'b0, xmax_ff} : cap_x;
   assign emy   = ({1'b0, ymax_ff} < cap_y) ? {1'b0, ymax_ff} : cap_y;

   logic signed [CW-1:0] xmin_s, ymin_s, xmax_s, ymax_s;
   assign xmin_s = $signed({3'b0, xmin_ff});
   assign ymin_s = $signed({3'b0, ymin_ff});
   assign xmax_s = $signed({2'b0, emx});
   assign ymax_s = $signed({2'b0, emy});

   req_type req_ff;
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
   end

   // Footprint set-up.
   logic signed [20:0] dx_c, dy_c;
   logic signed [23:0] lo_x, lo_y, hi_x, hi_y;
   logic signed [23:0] slo_x, slo_y, shi_x, shi_y;
   logic signed [CW-1:0] x0c, y0c, x1c, y1c;
   assign dx_c = $signed({1'b0, req_ff.pos_x}) - 21'sd128;
   assign dy_c = $signed({1'b0, req_ff.pos_y}) - 21'sd128;
   assign lo_x = 24'(dx_c) - $signed({13'b0, rx_ff}) + 24'sd255;
   assign lo_y = 24'(dy_c) - $signed({13'b0, ry_ff}) + 24'sd255;
   assign hi_x = 24'(dx_c) + $signed({13'b0, rx_ff});
   assign hi_y = 24'(dy_c) + $signed({13'b0, ry_ff});
   assign slo_x = lo_x >>> 8;
   assign slo_y = lo_y >>> 8;
   assign shi_x = hi_x >>> 8;
   assign shi_y = hi_y >>> 8;
   assign x0c  = slo_x[CW-1:0];
   assign y0c  = slo_y[CW-1:0];
   assign x1c  = shi_x[CW-1:0] + 16'sd1;
   assign y1c  = shi_y[CW-1:0] + 16'sd1;

   logic signed [20:0]   dx_ff, dy_ff;
   logic signed [CW-1:0] x_ff, y_ff, x0_ff, x1_ff, y1_ff;
   logic signed [CW-1:0] x_nx, y_nx;
   assign x_nx = x_ff + 16'sd1;
   assign y_nx = y_ff + 16'sd1;

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         dx_ff <= dx_c;
         dy_ff <= dy_c;
         x0_ff <= (x0c < xmin_s) ? xmin_s : x0c;
         x_ff  <= (x0c < xmin_s) ? xmin_s : x0c;
         y_ff  <= (y0c < ymin_s) ? ymin_s : y0c;
         x1_ff <= (x1c > xmax_s) ? xmax_s : x1c;
         y1_ff <= (y1c > ymax_s) ? ymax_s : y1c;
      end else if (cmd.acc_we) begin
         if (x_nx < x1_ff) begin
            x_ff <= x_nx;
         end else begin
            x_ff <= x0_ff;
            y_ff <= y_nx;
         end
      end
   end

   assign status.empty    = (x0_ff >= x1_ff) || (y_ff >= y1_ff);
   assign status.last_pix = (x_nx >= x1_ff) && (y_nx >= y1_ff);

   // Table index: scaled absolute offset from the pixel position.
   logic signed [24:0] off_x, off_y;
   logic [23:0]        abs_x, abs_y;
   logic [39:0]        prod_x_ff, prod_y_ff;
   logic [IDXW-1:0]    ix_ff, iy_ff;
   assign off_x = $signed({x_ff[CW-1], x_ff, 8'h00}) - 25'(dx_ff);
   assign off_y = $signed({y_ff[CW-1], y_ff, 8'h00}) - 25'(dy_ff);
   assign abs_x = off_x[24] ? 24'(-off_x) : 24'(off_x);
   assign abs_y = off_y[24] ? 24'(-off_y) : 24'(off_y);

   always_ff @(posedge clock) begin
      if (cmd.idx1) begin
         prod_x_ff <= abs_x * invx_ff;
         prod_y_ff <= abs_y * invy_ff;
      end
      if (cmd.idx2) begin
         ix_ff <= tbl_idx(prod_x_ff);
         iy_ff <= tbl_idx(prod_y_ff);
      end
   end

   // Filter table.
   logic [TAW-1:0] tbl_raddr;
   logic [15:0]    tbl_rdata;
   logic           tbl_we;
   assign tbl_raddr = TAW'(iy_ff) * TAW'(FILTER_TABLE_WIDTH) + TAW'(ix_ff);
   assign tbl_we    = cmd.tbl_we && (int'(req_item.table_index) < TBL_N);

   ftss_ram #(.WIDTH(16), .DEPTH(TBL_N)) u_tbl (
      .clock (clock),
      .we    (tbl_we),
      .waddr (TAW'(req_item.table_index)),
      .wdata (req_item.table_weight),
      .re    (cmd.mem_rd),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   // Pixel addresses.
   logic signed [CW-1:0] lx, ly;
   logic [12:0]          lpx, lpy;
   logic [PAW-1:0]       add_addr, rd_addr;
   assign lx       = x_ff - xmin_s;
   assign ly       = y_ff - ymin_s;
   assign add_addr = PAW'(ly) * PAW'(TILE_DIM) + PAW'(lx);
   assign lpx      = {1'b0, req_ff.pixel_x} - xmin_ff;
   assign lpy      = {1'b0, req_ff.pixel_y} - ymin_ff;
   assign rd_addr  = PAW'(lpy) * PAW'(TILE_DIM) + PAW'(lpx);

   logic pix_in_tile;
   assign pix_in_tile = ({1'b0, req_ff.pixel_x} >= xmin_ff) &&
                        ({2'b0, req_ff.pixel_x} < emx) &&
                        ({1'b0, req_ff.pixel_y} >= ymin_ff) &&
                        ({2'b0, req_ff.pixel_y} < emy);

   // Clearing sweep counter.
   logic [PAW-1:0] clr_ff;
   assign status.clr_last = (clr_ff == PAW'(PIX_N - 1));
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_we) begin
         clr_ff <= status.clr_last ? '0 : clr_ff + 1'b1;
      end
   end

   // Weighting.
   logic signed [32:0] k_ff;
   logic signed [49:0] pr_ff, pg_ff, pb_ff;
   logic signed [15:0] fw_ff;
   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         k_ff  <= $signed({1'b0, req_ff.sample_weight}) * $signed(tbl_rdata);
         fw_ff <= $signed(tbl_rdata);
      end
      if (cmd.mul2) begin
         pr_ff <= $signed({1'b0, req_ff.red}) * k_ff;
         pg_ff <= $signed({1'b0, req_ff.green}) * k_ff;
         pb_ff <= $signed({1'b0, req_ff.blue}) * k_ff;
      end
   end

   function automatic logic signed [39:0] sat40(input logic signed [39:0] a,
                                                input logic signed [27:0] b);
      logic signed [40:0] s;
      s = 41'(a) + 41'(b);
      if (s[40] != s[39]) begin
         sat40 = s[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
      end else begin
         sat40 = s[39:0];
      end
   endfunction

   acc_type acc_rdata, acc_wdata, acc_sum;
   logic signed [32:0] wsum;
   assign wsum          = 33'(acc_rdata.weight) + 33'(fw_ff);
   assign acc_sum.red   = sat40(acc_rdata.red, pr_ff[47:20]);
   assign acc_sum.green = sat40(acc_rdata.green, pg_ff[47:20]);
   assign acc_sum.blue  = sat40(acc_rdata.blue, pb_ff[47:20]);
   assign acc_sum.weight = (wsum[32] != wsum[31]) ?
                           (wsum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}}) : wsum[31:0];
   assign acc_wdata     = cmd.clr_we ? '0 : acc_sum;

   ftss_ram #(.WIDTH($bits(acc_type)), .DEPTH(PIX_N)) u_acc (
      .clock (clock),
      .we    (cmd.clr_we || cmd.acc_we),
      .waddr (cmd.clr_we ? clr_ff : add_addr),
      .wdata (acc_wdata),
      .re    (cmd.mem_rd || cmd.pix_rd),
      .raddr (cmd.pix_rd ? rd_addr : add_addr),
      .rdata (acc_rdata)
   );

   logic in_tile_ff;
   always_ff @(posedge clock) begin
      if (cmd.pix_rd) begin
         in_tile_ff <= pix_in_tile;
      end
   end

   always_comb begin
      rsp_item = '0;
      if (in_tile_ff) begin
         rsp_item.red_sum    = acc_rdata.red;
         rsp_item.green_sum  = acc_rdata.green;
         rsp_item.blue_sum   = acc_rdata.blue;
         rsp_item.weight_sum = acc_rdata.weight;
         rsp_item.in_tile    = 1'b1;
      end
   end

endmodule

// ===== sv/film_tile_sample_splat_unit.sv =====
`timescale 1ns / 1ps
// Table load: written as start is seen. Pixel read: S_PIXRD reads the word and
// S_PIXOUT strobes the result. Add sample: S_SETUP, S_CHECK, then per covered
// pixel S_IDX1, S_IDX2, S_MEMRD, S_MUL1, S_MUL2, S_WB. One request at a time,
// set by the per-pixel read-modify-write sequence on the accumulator RAM. Reset:
// synchronous; as for a tile clear, a clearing pass zeroes all TILE_DIM^2 (1024)
// accumulators, busy high meanwhile. The receiver cannot stall results.
// ----------------------------------------------------------------------------
// film_tile_sample_splat_unit
// Tabulated filter splatting of film samples into one tile of accumulators.
// ----------------------------------------------------------------------------
module film_tile_sample_splat_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ftss_pkg::req_type req_item,
   output logic              rsp_valid,
   output ftss_pkg::rsp_type rsp_item,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import ftss_pkg::*;

   cmd_type    cmd;
   status_type status;

   ftss_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_item.action),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   ftss_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   assign rsp_valid = cmd.rsp_valid;

endmodule
